[sv/lhr_pkg.sv]
// Package for the largest histogram rectangle block: sizes, payload types,
// stack entry layout and controller states. No dependencies.
package lhr_pkg;

    localparam int MAX_BARS    = 1024;
    localparam int HEIGHT_BITS = 16;
    localparam int IDX_W       = $clog2(MAX_BARS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int AREA_W      = HEIGHT_BITS + CNT_W;

    // fixed port field widths
    localparam int HEIGHT_IN_W = 16;
    localparam int START_W     = 10;
    localparam int END_W       = 11;
    localparam int AREA_OUT_W  = 26;

    typedef logic [HEIGHT_BITS-1:0] t_height;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [AREA_W-1:0]      t_area;

    typedef struct packed {
        t_height height;
        t_idx    start;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_LOAD   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

endpackage

[sv/lhr_bar_if.sv]
// Input channel interface: one bar (height, last flag) per transfer.
// Depends on lhr_pkg.
interface lhr_bar_if;
    import lhr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [HEIGHT_IN_W-1:0] height;
    logic                   last;

    modport source (output valid, output height, output last, input ready);
    modport sink   (input valid, input height, input last, output ready);
endinterface

[sv/lhr_res_if.sv]
// Result channel interface: best rectangle and overflow flag per transfer.
// Depends on lhr_pkg.
interface lhr_res_if;
    import lhr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [START_W-1:0]    start_index;
    logic [END_W-1:0]      end_index;
    logic [AREA_OUT_W-1:0] area;
    logic                  overflow;

    modport source (output valid, output start_index, output end_index,
                    output area, output overflow, input ready);
    modport sink   (input valid, input start_index, input end_index,
                    input area, input overflow, output ready);
endinterface

[sv/largest_histogram_rectangle_top.sv]
// Largest rectangle in a histogram, monotonic stack kept in a synchronous RAM.
// Depends on lhr_pkg, lhr_bar_if and lhr_res_if.
//
// Bars arrive one per transfer on i_bar; the bar with last set closes the
// sequence and one result (start index, exclusive end index, area, overflow)
// is sent on o_res, after which the block starts a fresh sequence. Up to
// MAX_BARS (1024) bars are taken per sequence; later bars only set overflow.
// The stack top lives in a register, the entries below it in a 1024 x 26
// RAM with a registered read. A bar that pops nothing is accepted in
// S_IDLE, then compared and pushed in S_CHECK. Every popped entry is
// scored in S_CHECK, which also issues the RAM read of the entry beneath,
// and S_LOAD then loads that entry as the new top; popping the bottom
// entry needs only the scoring step. The last bar drains the remaining
// stack the same way, then S_CHECK sees the empty stack and S_FINISH hands
// the result to the output register (holding while the previous result is
// still waiting). The output register lets the next sequence start while
// the previous result waits to be taken. No clearing pass is needed after
// reset: stack entries are always written before they are read.
module largest_histogram_rectangle_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lhr_bar_if.sink   i_bar,
    lhr_res_if.source o_res
);
    import lhr_pkg::*;

    // stack storage below the top entry
    t_entry mem [MAX_BARS];
    t_entry r_rd;

    t_state r_state, n_state;
    t_cnt   r_sp, n_sp;          // entries on the stack, top included
    t_cnt   r_pos, n_pos;        // bars taken in this sequence
    t_area  r_best_area, n_best_area;
    t_idx   r_best_start, n_best_start;
    t_cnt   r_best_end, n_best_end;
    logic   r_ovf, n_ovf;
    logic   r_drain, n_drain;    // last bar seen, emptying the stack
    t_entry r_top, n_top;        // stack top, valid when r_sp != 0

    // current bar
    t_height r_h, n_h;
    logic    r_last, n_last;
    logic    r_inrange, n_inrange;
    t_idx    r_s, n_s;           // start index the bar will be pushed with

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [START_W-1:0]    r_out_start, n_out_start;
    logic [END_W-1:0]      r_out_end, n_out_end;
    logic [AREA_OUT_W-1:0] r_out_area, n_out_area;
    logic                  r_out_ovf, n_out_ovf;

    logic  w_top_valid;
    t_cnt  w_width;
    t_area w_area;
    logic  w_pop;
    logic  w_push;
    logic  w_wr;
    logic  w_rd;
    t_cnt  w_sp_m1;
    t_cnt  w_sp_m2;
    logic  w_out_free;

    assign w_top_valid = (r_sp != '0);
    assign w_width     = r_pos - CNT_W'(r_top.start);
    assign w_area      = AREA_W'(r_top.height) * AREA_W'(w_width);
    assign w_sp_m1     = r_sp - CNT_W'(1);
    assign w_sp_m2     = r_sp - CNT_W'(2);
    assign w_out_free  = !r_out_valid || o_res.ready;

    // pop while the top is taller than an in-range bar, or unconditionally on drain
    assign w_pop  = (r_state == S_CHECK) && w_top_valid &&
                    (r_drain || (r_inrange && (r_top.height > r_h)));
    // equal-height top extends instead of pushing
    assign w_push = (r_state == S_CHECK) && !w_pop && !r_drain && r_inrange &&
                    (!w_top_valid || (r_top.height != r_h)) &&
                    (r_sp < CNT_W'(MAX_BARS));
    // old top spills to RAM on a push; pop fetches the entry beneath
    assign w_wr = w_push && w_top_valid;
    assign w_rd = w_pop && (r_sp > CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[w_sp_m1[IDX_W-1:0]] <= r_top;
        end
        if (w_rd) begin
            r_rd <= mem[w_sp_m2[IDX_W-1:0]];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_sp         = r_sp;
        n_pos        = r_pos;
        n_best_area  = r_best_area;
        n_best_start = r_best_start;
        n_best_end   = r_best_end;
        n_ovf        = r_ovf;
        n_drain      = r_drain;
        n_top        = r_top;
        n_h          = r_h;
        n_last       = r_last;
        n_inrange    = r_inrange;
        n_s          = r_s;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_start  = r_out_start;
        n_out_end    = r_out_end;
        n_out_area   = r_out_area;
        n_out_ovf    = r_out_ovf;

        unique case (r_state)
            S_IDLE: begin
                if (i_bar.valid) begin
                    n_h       = i_bar.height[HEIGHT_BITS-1:0];
                    n_last    = i_bar.last;
                    n_inrange = (r_pos < CNT_W'(MAX_BARS));
                    n_s       = r_pos[IDX_W-1:0];
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_pop) begin
                    // rectangle of the popped entry ends at the current position
                    if (w_area > r_best_area) begin
                        n_best_area  = w_area;
                        n_best_start = r_top.start;
                        n_best_end   = r_pos;
                    end
                    n_s  = r_top.start;
                    n_sp = w_sp_m1;
                    if (r_sp > CNT_W'(1)) begin
                        n_state = S_LOAD;
                    end
                end else if (r_drain) begin
                    n_state = S_FINISH;
                end else begin
                    if (w_push) begin
                        n_top = '{height: r_h, start: r_s};
                        n_sp  = r_sp + CNT_W'(1);
                    end
                    if (r_inrange) begin
                        n_pos = r_pos + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (r_last) begin
                        n_drain = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                n_top   = r_rd;
                n_state = S_CHECK;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_start  = START_W'(r_best_start);
                    n_out_end    = END_W'(r_best_end);
                    n_out_area   = AREA_OUT_W'(r_best_area);
                    n_out_ovf    = r_ovf;
                    // fresh sequence
                    n_sp         = '0;
                    n_pos        = '0;
                    n_best_area  = '0;
                    n_best_start = '0;
                    n_best_end   = '0;
                    n_ovf        = 1'b0;
                    n_drain      = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sp         <= '0;
            r_pos        <= '0;
            r_best_area  <= '0;
            r_best_start <= '0;
            r_best_end   <= '0;
            r_ovf        <= 1'b0;
            r_drain      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sp         <= n_sp;
            r_pos        <= n_pos;
            r_best_area  <= n_best_area;
            r_best_start <= n_best_start;
            r_best_end   <= n_best_end;
            r_ovf        <= n_ovf;
            r_drain      <= n_drain;
            r_out_valid  <= n_out_valid;
        end
        r_top       <= n_top;
        r_h         <= n_h;
        r_last      <= n_last;
        r_inrange   <= n_inrange;
        r_s         <= n_s;
        r_out_start <= n_out_start;
        r_out_end   <= n_out_end;
        r_out_area  <= n_out_area;
        r_out_ovf   <= n_out_ovf;
    end

    assign i_bar.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.start_index = r_out_start;
    assign o_res.end_index   = r_out_end;
    assign o_res.area        = r_out_area;
    assign o_res.overflow    = r_out_ovf;

endmodule

[tb/lhr_rect_checker.sv]
// Scoreboard for the largest histogram rectangle block: follows both channels,
// predicts each best rectangle with its own stack copy and compares the results.
// Depends on lhr_pkg, lhr_bar_if and lhr_res_if.
module lhr_rect_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lhr_bar_if   i_bar,
    lhr_res_if   i_res,
    output int   o_fails,
    output int   o_pending,
    output int   o_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import lhr_pkg::*;

    localparam int MAX_SHOWN = 200;

    typedef struct packed {
        logic [START_W-1:0]    start_index;
        logic [END_W-1:0]      end_index;
        logic [AREA_OUT_W-1:0] area;
        logic                  overflow;
    } t_rect;

    // predictor state, one sequence at a time
    t_height stk_h [MAX_BARS];
    t_idx    stk_s [MAX_BARS];
    t_cnt    depth;
    t_cnt    bar_count;
    t_area   best_area;
    t_idx    best_start;
    t_cnt    best_end;
    logic    overflowed;

    t_rect   rect_q [$];
    int      fail_n;
    int      result_n;

    function automatic void clear_seq();
        depth      = '0;
        bar_count  = '0;
        best_area  = '0;
        best_start = '0;
        best_end   = '0;
        overflowed = 1'b0;
    endfunction

    // strictly larger area wins, so the first of equal rectangles stays
    function automatic void score_rect(t_height h, t_idx s, t_cnt e);
        t_area a;
        a = t_area'(h) * t_area'(e - t_cnt'(s));
        if (a > best_area) begin
            best_area  = a;
            best_start = s;
            best_end   = e;
        end
    endfunction

    function automatic void pop_top(t_cnt e);
        t_idx top;
        top = t_idx'(depth - t_cnt'(1));
        score_rect(stk_h[top], stk_s[top], e);
        depth = depth - t_cnt'(1);
    endfunction

    function automatic void take_bar(t_height h, logic lst);
        t_idx  run_start;
        t_rect r;
        if (bar_count < t_cnt'(MAX_BARS)) begin
            run_start = t_idx'(bar_count);
            while (depth != 0 && stk_h[t_idx'(depth - t_cnt'(1))] > h) begin
                run_start = stk_s[t_idx'(depth - t_cnt'(1))];
                pop_top(bar_count);
            end
            if ((depth == 0 || stk_h[t_idx'(depth - t_cnt'(1))] != h)
                    && depth < t_cnt'(MAX_BARS)) begin
                stk_h[t_idx'(depth)] = h;
                stk_s[t_idx'(depth)] = run_start;
                depth = depth + t_cnt'(1);
            end
            bar_count = bar_count + t_cnt'(1);
        end else begin
            overflowed = 1'b1;
        end
        if (lst) begin
            while (depth != 0) begin
                pop_top(bar_count);
            end
            r.start_index = best_start;
            r.end_index   = best_end;
            r.area        = best_area[AREA_OUT_W-1:0];
            r.overflow    = overflowed;
            rect_q.push_back(r);
            clear_seq();
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_n++;
            if (fail_n <= MAX_SHOWN) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        end
    endfunction

    function automatic void check_rect();
        t_rect want;
        result_n++;
        if (rect_q.size() == 0) begin
            fail_n++;
            $display("%0t: unexpected result, expected none, actual start %0d end %0d area %0d ovf %0d",
                     $time, i_res.start_index, i_res.end_index, i_res.area, i_res.overflow);
        end else begin
            want = rect_q[0];
            rect_q.delete(0);
            check_field("start_index", 32'(want.start_index), 32'(i_res.start_index));
            check_field("end_index",   32'(want.end_index),   32'(i_res.end_index));
            check_field("area",        32'(want.area),        32'(i_res.area));
            check_field("overflow",    32'(want.overflow),    32'(i_res.overflow));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_seq();
            rect_q.delete();
            fail_n   = 0;
            result_n = 0;
        end else begin
            if (i_bar.valid && i_bar.ready) begin
                take_bar(t_height'(i_bar.height), i_bar.last);
            end
            if (i_res.valid && i_res.ready) begin
                check_rect();
            end
        end
        o_fails   <= fail_n;
        o_pending <= rect_q.size();
        o_results <= result_n;
    end

endmodule

[tb/tb_largest_histogram_rectangle_top.sv]
// Top of the largest histogram rectangle testbench: clock, reset, bar stimulus
// with random pacing, result back-pressure and the verdict.
// Depends on lhr_pkg, lhr_bar_if, lhr_res_if, lhr_rect_checker and the block.
module tb_largest_histogram_rectangle_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lhr_pkg::*;

    // bars in the short random sequences; the two full-capacity runs come on top
    localparam int SHORT_BARS    = 240;
    // the block is idle once its last result is taken; this margin is ample
    localparam int SETTLE_CYCLES = 64;

    // height patterns for one sequence
    typedef enum int {
        RUN_NOISE,  // full 16-bit range, every bit toggles
        RUN_LOW,    // 0..3: zeros, equal neighbors, ties
        RUN_BYTE,   // 0..255
        RUN_RISE,   // non-decreasing: deep stack, drain does the work
        RUN_FALL,   // non-increasing: pops on almost every bar
        RUN_RAMP,   // strictly rising across the full 1024 bars
        RUN_FLAT    // 1024 bars at max height, then ignored overflow bars
    } t_run;

    logic clk;
    logic rst_n;

    lhr_bar_if bar_ch ();
    lhr_res_if res_ch ();

    int chk_fails;
    int chk_pending;
    int chk_results;
    int bars_sent;
    int runs_sent;
    bit bar_gaps;    // sender idles between bars in this sequence
    bit res_stalls;  // receiver holds off results in this sequence

    largest_histogram_rectangle_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_bar   (bar_ch),
        .o_res   (res_ch)
    );

    lhr_rect_checker rect_chk (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_bar     (bar_ch),
        .i_res     (res_ch),
        .o_fails   (chk_fails),
        .o_pending (chk_pending),
        .o_results (chk_results)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well past the slowest legal run (under 1 ms of traffic).
    initial begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

    // Per-sequence pacing: mostly gappy, sometimes back to back on each side.
    task automatic pick_pacing();
        bar_gaps   = ($urandom_range(0, 3) != 0);
        res_stalls = ($urandom_range(0, 3) != 0);
    endtask

    // One bar transfer. valid is only dropped when a gap follows, so a
    // back-to-back bar never sees valid lowered and raised in one step.
    task automatic send_bar(input t_height h, input logic lst);
        int gap;
        gap = bar_gaps ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0) begin
            bar_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bar_ch.valid  <= 1'b1;
        bar_ch.height <= h;
        bar_ch.last   <= lst;
        do @(posedge clk); while (!bar_ch.ready);
        bars_sent++;
    endtask

    // Fixed height list, last flag on the final bar.
    task automatic send_seq(input int hs[$]);
        pick_pacing();
        foreach (hs[i]) begin
            send_bar(t_height'(hs[i]), i == hs.size() - 1);
        end
        runs_sent++;
    endtask

    // Generated sequence of len bars following one height pattern.
    task automatic send_run(input t_run sty, input int len);
        int hv;
        hv = 0;
        pick_pacing();
        for (int k = 0; k < len; k++) begin
            case (sty)
                RUN_NOISE: hv = int'($urandom_range(0, 65535));
                RUN_LOW:   hv = int'($urandom_range(0, 3));
                RUN_BYTE:  hv = int'($urandom_range(0, 255));
                RUN_RISE: begin
                    hv = (k == 0) ? int'($urandom_range(0, 255))
                                  : hv + int'($urandom_range(0, 40));
                    if (hv > 65535) hv = 65535;
                end
                RUN_FALL: begin
                    hv = (k == 0) ? int'($urandom_range(60000, 65535))
                                  : hv - int'($urandom_range(0, 40));
                    if (hv < 0) hv = 0;
                end
                // 64 per step keeps every bar strictly above the previous
                RUN_RAMP:  hv = k * 64 + int'($urandom_range(0, 63));
                // heights past capacity must be ignored, so make them random
                RUN_FLAT:  hv = (k < MAX_BARS) ? 65535 : int'($urandom_range(0, 65535));
                default:   hv = 0;
            endcase
            send_bar(t_height'(hv), k == len - 1);
        end
        runs_sent++;
    endtask

    // Short sequences with random patterns until n more bars have gone out.
    // Most are 1..24 bars, one in ten runs longer to stack deeper.
    task automatic send_short(input int n);
        int   goal;
        int   len;
        t_run sty;
        goal = bars_sent + n;
        while (bars_sent < goal) begin
            sty = t_run'($urandom_range(int'(RUN_NOISE), int'(RUN_FALL)));
            len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(25, 120))
                                              : int'($urandom_range(1, 24));
            send_run(sty, len);
        end
    endtask

    // Result side: either ready waits early, so a result is taken as soon as it
    // shows, or it stays low until a result shows and only rises after a random stall.
    initial begin
        res_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (res_stalls && $urandom_range(0, 1) == 1) begin
                res_ch.ready <= 1'b0;
                do @(posedge clk); while (!res_ch.valid);
                repeat ($urandom_range(0, 5)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    // Stimulus and verdict.
    initial begin
        int dq[$];
        rst_n         <= 1'b0;
        bar_ch.valid  <= 1'b0;
        bar_ch.height <= '0;
        bar_ch.last   <= 1'b0;
        bars_sent  = 0;
        runs_sent  = 0;
        bar_gaps   = 1'b0;
        res_stalls = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single bars at both extremes (zero-area result for 0),
        // all zeros, a tie where the first rectangle must stay, falling,
        // rising, equal heights (no re-push), and a mix of extremes.
        dq = '{0};                        send_seq(dq);
        dq = '{65535};                    send_seq(dq);
        dq = '{0, 0, 0};                  send_seq(dq);
        dq = '{2, 0, 2};                  send_seq(dq);
        dq = '{5, 4, 3, 2, 1};            send_seq(dq);
        dq = '{1, 2, 3, 4};               send_seq(dq);
        dq = '{7, 7, 7};                  send_seq(dq);
        dq = '{65535, 0, 65535, 32768};   send_seq(dq);

        // Random: short sequences around two full-capacity runs. The ramp
        // fills the stack to all 1024 entries and ends exactly at capacity;
        // the flat run hits maximum area, then 1..6 extra bars overflow, the
        // last of which closes the sequence.
        send_short(SHORT_BARS / 4);
        send_run(RUN_RAMP, MAX_BARS);
        send_short(SHORT_BARS / 2);
        send_run(RUN_FLAT, MAX_BARS + int'($urandom_range(1, 6)));
        send_short(SHORT_BARS / 4);

        bar_ch.valid <= 1'b0;
        bar_ch.last  <= 1'b0;

        // let the checker book the final bar before polling its count
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d bars in %0d sequences, %0d rectangles checked.",
                 bars_sent, runs_sent, chk_results);
        $display("Covered full-depth stack, overflow, ties, zero and equal heights.");
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[largest_histogram_rectangle_top.f]
sv/lhr_pkg.sv
sv/lhr_bar_if.sv
sv/lhr_res_if.sv
sv/largest_histogram_rectangle_top.sv
tb/lhr_rect_checker.sv
tb/tb_largest_histogram_rectangle_top.sv
